/* rtl/lmsanc_pkg.sv */
// Shared types, constants and tables for the LMS adaptive noise canceller.
// No dependencies; the sequencer, datapath and top-level files import this package.
package lmsanc_pkg;

  localparam int ADAPTIVE_TAPS_DEF = 60;
  localparam int PATH_TAPS_DEF     = 30;
  localparam int WEIGHT_WIDTH_DEF  = 24;

  localparam int SAMPLE_W  = 12;
  localparam int DAC_W     = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int PATH_LEN  = 30;

  localparam logic [31:0] LCG_MUL  = 32'd1664525;
  localparam logic [31:0] LCG_ADD  = 32'd1013904223;
  localparam logic [31:0] LCG_SEED = 32'hDEADBEEF;

  localparam logic [CFG_W-1:0] STEP_RESET = 16'd328;
  localparam logic [CFG_W-1:0] AMP_RESET  = 16'd19661;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE = 8'd0,
    CFG_NOISE_AMP = 8'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_PATH,
    OP_FILT,
    OP_UPD
  } tap_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOISE,
    ST_PUSH,
    ST_PATH,
    ST_PATH_WAIT,
    ST_FILT,
    ST_FILT_WAIT,
    ST_ERR,
    ST_UPD,
    ST_UPD_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    take;
    logic    noise;
    logic    push;
    logic    acc_clr;
    logic    issue;
    tap_op_e op;
    logic    path_done;
    logic    err_done;
    logic    scale;
    logic    upd_done;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

  localparam logic signed [15:0] PATH_TABLE [PATH_LEN] = '{
    -16'sd52, -16'sd66, -16'sd39, 16'sd59, 16'sd223, 16'sd331, 16'sd197, -16'sd275,
    -16'sd914, -16'sd1248, -16'sd711, 16'sd999, 16'sd3611, 16'sd6285, 16'sd7982,
    16'sd7982, 16'sd6285, 16'sd3611, 16'sd999, -16'sd711, -16'sd1248, -16'sd914,
    -16'sd275, 16'sd197, 16'sd331, 16'sd223, 16'sd59, -16'sd39, -16'sd66, -16'sd52
  };

  function automatic logic signed [15:0] path_coeff(input int k);
    logic signed [15:0] c;
    c = '0;
    if (k < PATH_LEN) begin
      c = PATH_TABLE[5'(k)];
    end
    return c;
  endfunction

endpackage

/* rtl/lmsanc_ctrl.sv */
// Sequencer for the noise canceller: steps one item through noise, FIR, LMS and update.
// Depends on lmsanc_pkg for state, command and status types.
module lmsanc_ctrl #(
  parameter int ADAPTIVE_TAPS = lmsanc_pkg::ADAPTIVE_TAPS_DEF,
  parameter int PATH_TAPS     = lmsanc_pkg::PATH_TAPS_DEF,
  parameter int KW            = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lmsanc_pkg::status_t status_i,
  output lmsanc_pkg::cmd_t    cmd_o,
  output logic [KW-1:0]       k_o
);
  import lmsanc_pkg::*;

  state_e        state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic          path_last, adapt_last;

  assign path_last  = (k_q == KW'(PATH_TAPS - 1));
  assign adapt_last = (k_q == KW'(ADAPTIVE_TAPS - 1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign k_o        = k_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_NOISE;
      ST_NOISE:     state_d = ST_PUSH;
      ST_PUSH:      state_d = ST_PATH;
      ST_PATH:      if (path_last) state_d = ST_PATH_WAIT;
      ST_PATH_WAIT: if (!status_i.pipe_busy) state_d = ST_FILT;
      ST_FILT:      if (adapt_last) state_d = ST_FILT_WAIT;
      ST_FILT_WAIT: if (!status_i.pipe_busy) state_d = ST_ERR;
      ST_ERR:       state_d = ST_UPD;
      ST_UPD:       if (adapt_last) state_d = ST_UPD_WAIT;
      ST_UPD_WAIT:  if (!status_i.pipe_busy) state_d = ST_OUT;
      ST_OUT:       if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.op = OP_PATH;
    k_d = k_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.take = in_valid_i;
      ST_NOISE: cmd_o.noise = 1'b1;
      ST_PUSH: begin
        cmd_o.push    = 1'b1;
        cmd_o.acc_clr = 1'b1;
        k_d           = '0;
      end
      ST_PATH: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_PATH;
        k_d         = path_last ? '0 : k_q + 1'b1;
      end
      ST_PATH_WAIT: begin
        cmd_o.path_done = !status_i.pipe_busy;
        cmd_o.acc_clr   = !status_i.pipe_busy;
      end
      ST_FILT: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_FILT;
        k_d         = adapt_last ? '0 : k_q + 1'b1;
      end
      ST_FILT_WAIT: cmd_o.err_done = !status_i.pipe_busy;
      ST_ERR:       cmd_o.scale = 1'b1;
      ST_UPD: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = OP_UPD;
        k_d         = adapt_last ? '0 : k_q + 1'b1;
      end
      ST_UPD_WAIT: cmd_o.upd_done = !status_i.pipe_busy;
      ST_OUT:      cmd_o.out_load = status_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

/* rtl/lmsanc_dpath.sv */
// Datapath: noise generator, history and weight memories, shared MAC pipeline, output register.
// Depends on lmsanc_pkg; driven by lmsanc_ctrl through cmd_t and status_t.
module lmsanc_dpath #(
  parameter int ADAPTIVE_TAPS = lmsanc_pkg::ADAPTIVE_TAPS_DEF,
  parameter int PATH_TAPS     = lmsanc_pkg::PATH_TAPS_DEF,
  parameter int WEIGHT_WIDTH  = lmsanc_pkg::WEIGHT_WIDTH_DEF,
  parameter int KW            = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lmsanc_pkg::cmd_t                    cmd_i,
  input  logic [KW-1:0]                       k_i,
  output lmsanc_pkg::status_t                 status_o,
  input  logic [lmsanc_pkg::SAMPLE_W-1:0]     adc_i,
  input  logic                                cfg_we_i,
  input  logic [lmsanc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lmsanc_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [lmsanc_pkg::DAC_W-1:0]        clean_o,
  output logic [lmsanc_pkg::DAC_W-1:0]        noisy_o
);
  import lmsanc_pkg::*;

  localparam int HD      = (ADAPTIVE_TAPS > PATH_TAPS) ? ADAPTIVE_TAPS : PATH_TAPS;
  localparam int HW      = $clog2(HD);
  localparam int FW      = $clog2(HD + 1);
  localparam int WAW     = $clog2(ADAPTIVE_TAPS);
  localparam int WW      = WEIGHT_WIDTH;
  localparam int SE_W    = 41;
  localparam int PROD_W  = SE_W + 16;
  localparam int ACC_W   = WW + 24;
  localparam int Y_W     = ACC_W - 22;
  localparam int DIFF_W  = (Y_W + 1 > 25) ? Y_W + 1 : 25;
  localparam int RND_W   = PROD_W - 24;

  localparam logic signed [42:0]       N_HALF    = 43'sd16777216;
  localparam logic signed [25:0]       N_OFFSET  = 26'sd16777216;
  localparam logic signed [PROD_W-1:0] P_HALF    = PROD_W'(64'sd8388608);
  localparam logic signed [ACC_W-1:0]  A_HALF15  = ACC_W'(64'sd16384);
  localparam logic signed [ACC_W-1:0]  A_HALF22  = ACC_W'(64'sd2097152);
  localparam logic signed [RND_W:0]    W_HI      = (RND_W + 1)'((64'sd1 <<< (WW - 1)) - 1);
  localparam logic signed [RND_W:0]    W_LO      = -W_HI - 1;
  localparam logic signed [DIFF_W-1:0] E_HI      = DIFF_W'(64'sd8388607);
  localparam logic signed [DIFF_W-1:0] E_LO      = -E_HI - 1;

  function automatic logic [DAC_W-1:0] dac_code(input logic signed [23:0] q);
    logic signed [25:0] v;
    logic signed [39:0] num;
    logic [DAC_W-1:0]   c;
    v   = 26'(q) + 26'sd32768;
    num = (40'(v) <<< 12) - 40'(v) + 40'sd65536;
    if (num < 0) begin
      c = '0;
    end else if (num[39:16] > 24'd4095) begin
      c = '1;
    end else begin
      c = num[27:16];
    end
    return c;
  endfunction

  logic [CFG_W-1:0]         step_q, amp_q;
  logic [31:0]              lcg_q;
  logic signed [15:0]       s_q, x_q;
  logic [HW-1:0]            head_q, head_next;
  logic [FW-1:0]            fill_q;
  logic                     wvalid_q;
  logic signed [15:0]       hist_mem [HD];
  logic signed [WW-1:0]     w_mem [ADAPTIVE_TAPS];

  logic signed [15:0]       h_rd_q, c1_q;
  logic signed [WW-1:0]     w_rd_q, w2_q;
  logic                     v1_q, v2_q, hv1_q;
  tap_op_e                  op1_q, op2_q;
  logic [WAW-1:0]           k1_q, k2_q;
  logic signed [PROD_W-1:0] prod2_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [16:0]       d_q;
  logic signed [23:0]       e_q;
  logic signed [SE_W-1:0]   se_q;
  logic                     out_valid_q;
  logic [DAC_W-1:0]         clean_q, noisy_q;

  logic [HW:0]              hdiff;
  logic [HW-1:0]            haddr;
  logic signed [25:0]       xraw;
  logic signed [42:0]       nprod, nrnd;
  logic signed [15:0]       x_d;
  logic signed [15:0]       h1;
  logic signed [WW-1:0]     w1;
  logic signed [SE_W-1:0]   opa;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prnd;
  logic signed [RND_W:0]    wsum;
  logic signed [WW-1:0]     wnew;
  logic signed [ACC_W-1:0]  arnd15, arnd22;
  logic signed [16:0]       pathv;
  logic signed [DIFF_W-1:0] diff;
  logic signed [23:0]       e_d;

  assign hdiff     = {1'b0, head_q} - {1'b0, k_i};
  assign haddr     = hdiff[HW] ? HW'(hdiff + (HW + 1)'(HD)) : hdiff[HW-1:0];
  assign head_next = (head_q == HW'(HD - 1)) ? '0 : head_q + 1'b1;

  assign xraw  = $signed({1'b0, lcg_q[23:0], 1'b0}) - N_OFFSET;
  assign nprod = $signed({1'b0, amp_q}) * xraw;
  assign nrnd  = (nprod + N_HALF) >>> 25;
  assign x_d   = (nrnd > 43'sd32767) ? 16'sd32767 :
                 (nrnd < -43'sd32768) ? -16'sd32768 : nrnd[15:0];

  assign h1 = hv1_q ? h_rd_q : '0;
  assign w1 = wvalid_q ? w_rd_q : '0;

  always_comb begin
    unique case (op1_q)
      OP_PATH: opa = SE_W'(c1_q);
      OP_FILT: opa = SE_W'(w1);
      OP_UPD:  opa = se_q;
      default: opa = '0;
    endcase
  end

  assign prod = opa * h1;
  assign prnd = (prod2_q + P_HALF) >>> 24;
  assign wsum = (RND_W + 1)'(w2_q) + (RND_W + 1)'($signed(prnd[RND_W-1:0]));
  assign wnew = (wsum > W_HI) ? W_HI[WW-1:0] : (wsum < W_LO) ? W_LO[WW-1:0] : wsum[WW-1:0];

  assign arnd15 = (acc_q + A_HALF15) >>> 15;
  assign pathv  = (arnd15 > ACC_W'(64'sd32767)) ? 17'sd32767 :
                  (arnd15 < ACC_W'(-64'sd32768)) ? -17'sd32768 : arnd15[16:0];
  assign arnd22 = (acc_q + A_HALF22) >>> 22;
  assign diff   = DIFF_W'(d_q) - DIFF_W'($signed(arnd22[Y_W-1:0]));
  assign e_d    = (diff > E_HI) ? E_HI[23:0] : (diff < E_LO) ? E_LO[23:0] : diff[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      amp_q       <= AMP_RESET;
      lcg_q       <= LCG_SEED;
      head_q      <= '0;
      fill_q      <= '0;
      wvalid_q    <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_STEP_SIZE) step_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CFG_NOISE_AMP) amp_q <= cfg_data_i;
      if (cmd_i.take) lcg_q <= lcg_q * LCG_MUL + LCG_ADD;
      if (cmd_i.push) begin
        head_q <= head_next;
        if (fill_q != FW'(HD)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.upd_done) wvalid_q <= 1'b1;
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      out_valid_q <= cmd_i.out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) s_q <= $signed({~adc_i[SAMPLE_W-1], adc_i[SAMPLE_W-2:0], 4'b0000});
    if (cmd_i.noise) x_q <= x_d;
    if (cmd_i.push) hist_mem[head_next] <= x_q;
    if (cmd_i.issue) begin
      h_rd_q <= hist_mem[haddr];
      w_rd_q <= w_mem[k_i[WAW-1:0]];
    end
    hv1_q   <= (FW'(k_i) < fill_q);
    c1_q    <= path_coeff(int'(k_i));
    op1_q   <= cmd_i.op;
    k1_q    <= k_i[WAW-1:0];
    op2_q   <= op1_q;
    k2_q    <= k1_q;
    w2_q    <= w1;
    prod2_q <= prod;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (v2_q && op2_q != OP_UPD) begin
      acc_q <= acc_q + $signed(prod2_q[ACC_W-1:0]);
    end
    if (v2_q && op2_q == OP_UPD) w_mem[k2_q] <= wnew;
    if (cmd_i.path_done) d_q <= 17'(s_q) + pathv;
    if (cmd_i.err_done) e_q <= e_d;
    if (cmd_i.scale) se_q <= $signed({1'b0, step_q}) * e_q;
    if (cmd_i.out_load) begin
      clean_q <= dac_code(e_q);
      noisy_q <= dac_code(24'(d_q));
    end
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign clean_o            = clean_q;
  assign noisy_o            = noisy_q;

endmodule

/* rtl/lms_adaptive_noise_canceller_unit.sv */
// Top level of the LMS adaptive noise canceller: sequencer plus datapath.
// Depends on lmsanc_pkg, lmsanc_ctrl and lmsanc_dpath.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata[11:0] adc_sample
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata[11:0] clean_dac, [23:12] noisy_dac
//   cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each item is processed by the single shared multiply-accumulate pipeline, which walks
// the path FIR, LMS filter and update in turn.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset restores seed, registers, zero history and zero weights at once.
module lms_adaptive_noise_canceller_unit #(
  parameter int ADAPTIVE_TAPS = lmsanc_pkg::ADAPTIVE_TAPS_DEF,
  parameter int PATH_TAPS     = lmsanc_pkg::PATH_TAPS_DEF,
  parameter int WEIGHT_WIDTH  = lmsanc_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [11:0] adc_sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // [11:0] clean_dac, [23:12] noisy_dac
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lmsanc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lmsanc_pkg::CFG_W-1:0]     cfg_data_i
);
  import lmsanc_pkg::*;

  localparam int HD = (ADAPTIVE_TAPS > PATH_TAPS) ? ADAPTIVE_TAPS : PATH_TAPS;
  localparam int KW = $clog2(HD);

  cmd_t             cmd;
  status_t          status;
  logic [KW-1:0]    k;
  logic [DAC_W-1:0] clean, noisy;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {noisy, clean};

  lmsanc_ctrl #(
    .ADAPTIVE_TAPS(ADAPTIVE_TAPS),
    .PATH_TAPS    (PATH_TAPS),
    .KW           (KW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd),
    .k_o       (k)
  );

  lmsanc_dpath #(
    .ADAPTIVE_TAPS(ADAPTIVE_TAPS),
    .PATH_TAPS    (PATH_TAPS),
    .WEIGHT_WIDTH (WEIGHT_WIDTH),
    .KW           (KW)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .k_i        (k),
    .status_o   (status),
    .adc_i      (s_axis_tdata[SAMPLE_W-1:0]),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .clean_o    (clean),
    .noisy_o    (noisy)
  );

endmodule

/* rtl/lmsanc_checker.sv */
// Port-level checks for the noise canceller top level, bound to every instance.
// Depends on lms_adaptive_noise_canceller_unit port names only.
module lmsanc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while item in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared right after input");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> cfg_ready_o && $past(!s_axis_tready))
    else $error("result raised outside output state");

endmodule

bind lms_adaptive_noise_canceller_unit lmsanc_checker u_lmsanc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .cfg_ready_o  (cfg_ready_o)
);
